### rtl/core/lfuc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared types and constants of the LFU key-value store with LRU tie-break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 32;
   localparam int KEY_BITS   = 32;
   localparam int DATA_BITS  = 32;
   localparam int CAP_BITS   = 5;

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                        func;
      logic signed [KEY_BITS-1:0]  lookup_key;
      logic signed [DATA_BITS-1:0] write_value;
   } req_word_type;

   typedef struct packed {
      logic                        hit;
      logic signed [DATA_BITS-1:0] read_value;
   } rsp_word_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                 touch_en;
      logic                 write_en;
      logic                 evict_en;
      logic                 insert_en;
      logic [IDX_BITS-1:0]  target;
      logic [RANK_BITS-1:0] ref_rank;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] data;
   } cell_cmd_type;

   typedef struct packed {
      logic                  valid;
      logic                  match;
      logic [DATA_BITS-1:0]  data;
      logic [RANK_BITS-1:0]  rank;
   } cell_stat_type;

   // eviction candidate passed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_BITS-1:0]  rank;
      logic [IDX_BITS-1:0]   index;
   } cand_type;

endpackage
`default_nettype wire

### rtl/core/lfuc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_cell
// One store entry: key, data, use count and recency rank, plus one stage of
// the victim search chain.
// ----------------------------------------------------------------------------
module lfuc_cell
   import lfuc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [IDX_BITS-1:0] my_index,
   input  wire cell_cmd_type        cmd,
   input  wire cand_type            cand_left,
   output cand_type                 cand_right,
   output cell_stat_type            stat
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   cand_type              cand_ff, cand_in;
   logic                  is_target;
   logic                  i_win;

   assign is_target = (cmd.target == my_index);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      if (cmd.touch_en) begin
         if (is_target) begin
            rank_in = '0;
            if (count_ff != '1) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            if (cmd.write_en) begin
               data_in = cmd.data;
            end
         end else if (valid_ff && rank_ff < cmd.ref_rank) begin
            rank_in = rank_ff + RANK_BITS'(1);
         end
      end else if (cmd.evict_en) begin
         if (is_target) begin
            valid_in = 1'b0;
         end else if (valid_ff && rank_ff > cmd.ref_rank) begin
            rank_in = rank_ff - RANK_BITS'(1);
         end
      end else if (cmd.insert_en) begin
         if (is_target) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            data_in  = cmd.data;
            count_in = COUNT_BITS'(1);
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_ff + RANK_BITS'(1);
         end
      end
   end

   // lower count wins, older entry wins a tie
   assign i_win = valid_ff && (!cand_left.valid || count_ff < cand_left.count ||
                  (count_ff == cand_left.count && rank_ff > cand_left.rank));

   always_comb begin
      cand_in = cand_left;
      if (i_win) begin
         cand_in.valid = 1'b1;
         cand_in.count = count_ff;
         cand_in.rank  = rank_ff;
         cand_in.index = my_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         cand_ff.valid  <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         cand_ff.valid  <= cand_in.valid;
      end
      key_ff        <= key_in;
      data_ff       <= data_in;
      count_ff      <= count_in;
      rank_ff       <= rank_in;
      cand_ff.count <= cand_in.count;
      cand_ff.rank  <= cand_in.rank;
      cand_ff.index <= cand_in.index;
   end

   assign cand_right = cand_ff;

   assign stat.valid = valid_ff;
   assign stat.match = valid_ff && (key_ff == cmd.key);
   assign stat.data  = data_ff;
   assign stat.rank  = rank_ff;

endmodule
`default_nettype wire

### rtl/core/lfu_cache_lru_tiebreak_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top
// Fully associative key-value store with least-frequently-used replacement
// and least-recently-used tie-break, built as a row of entry cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            word
//  req_     in         req_valid/req_stall  req_word_type (func, key, value)
//  rsp_     out        rsp_valid/rsp_stall  rsp_word_type (hit, read_value)
//  csr_     in         csr_valid/csr_ready  capacity_in_use, 5 bits
//
//  get, put hit, put with capacity zero: lookup, then respond.
//  put miss with room: lookup, insert, respond.
//  each eviction adds a search along the victim candidate chain through
//  the cells and an evict step.
//  one word in flight; the next is accepted once the response is registered.
//  synchronous reset empties the store and sets capacity to 16.
//  a stalled response holds in the output register.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top
   import lfuc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_word_type        req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_word_type             rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_BITS-1:0] csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_LOOKUP  = 6'b000010,
      ST_SEARCH  = 6'b000100,
      ST_EVICT   = 6'b001000,
      ST_INSERT  = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   req_word_type          req_ff, req_in;
   rsp_word_type          res_ff, res_in;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic [IDX_BITS-1:0]   search_cnt_ff, search_cnt_in;

   cell_cmd_type          cmd;
   cand_type              cand_chain [ENTRIES+1];
   cell_stat_type         stat [ENTRIES];
   cand_type              victim;

   logic [ENTRIES-1:0]    valid_vec;
   logic [ENTRIES-1:0]    match_vec;
   logic                  found;
   logic [IDX_BITS-1:0]   found_idx;
   logic [RANK_BITS-1:0]  found_rank;
   logic [DATA_BITS-1:0]  found_data;
   logic                  free_found;
   logic [IDX_BITS-1:0]   free_idx;

   logic [CMP_BITS-1:0]   cap_wide, cap_eff, occ_wide;
   logic                  cap_zero;
   logic                  is_put;
   logic                  rsp_slot_free;

   // entry cells
   assign cand_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfuc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_index   (IDX_BITS'(g)),
         .cmd        (cmd),
         .cand_left  (cand_chain[g]),
         .cand_right (cand_chain[g+1]),
         .stat       (stat[g])
      );
   end

   assign victim = cand_chain[ENTRIES];

   always_comb begin
      found_idx  = '0;
      found_rank = '0;
      found_data = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_vec[i] = stat[i].valid;
         match_vec[i] = stat[i].match;
         if (stat[i].match) begin
            found_idx  = found_idx  | IDX_BITS'(i);
            found_rank = found_rank | stat[i].rank;
            found_data = found_data | stat[i].data;
         end
      end
      // lowest free index
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!stat[i].valid) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   assign found = |match_vec;

   assign is_put   = (req_ff.func == FUNC_PUT);
   assign cap_wide = CMP_BITS'(cap_ff);
   assign cap_eff  = (cap_wide > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_wide;
   assign cap_zero = (cap_ff == '0);
   assign occ_wide = CMP_BITS'(occ_ff);

   // cell commands
   always_comb begin
      cmd           = '0;
      cmd.key       = req_ff.lookup_key;
      cmd.data      = req_ff.write_value;
      case (state_ff)
         ST_LOOKUP: begin
            if (found && (!is_put || !cap_zero)) begin
               cmd.touch_en = 1'b1;
               cmd.write_en = is_put;
               cmd.target   = found_idx;
               cmd.ref_rank = found_rank;
            end
         end
         ST_EVICT: begin
            cmd.evict_en = 1'b1;
            cmd.target   = victim.index;
            cmd.ref_rank = victim.rank;
         end
         ST_INSERT: begin
            cmd.insert_en = 1'b1;
            cmd.target    = free_idx;
         end
         default: begin
         end
      endcase
   end

   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      occ_in        = occ_ff;
      search_cnt_in = search_cnt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            res_in.hit        = found;
            res_in.read_value = (!is_put && found) ? found_data : '1;
            search_cnt_in     = '0;
            if (is_put && !found && !cap_zero) begin
               state_in = (occ_wide >= cap_eff) ? ST_SEARCH : ST_INSERT;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SEARCH: begin
            search_cnt_in = search_cnt_ff + IDX_BITS'(1);
            if (search_cnt_ff == IDX_BITS'(ENTRIES - 1)) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            occ_in        = occ_ff - OCC_BITS'(1);
            search_cnt_in = '0;
            // lowered capacity may need several evictions
            state_in = ((occ_wide - CMP_BITS'(1)) >= cap_eff) ? ST_SEARCH : ST_INSERT;
         end
         ST_INSERT: begin
            occ_in   = occ_ff + OCC_BITS'(1);
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cap_in = (csr_valid && csr_ready) ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cap_ff        <= CAP_RESET;
         occ_ff        <= '0;
         search_cnt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cap_ff        <= cap_in;
         occ_ff        <= occ_in;
         search_cnt_ff <= search_cnt_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // checks
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_BITS'($countones(valid_vec)))
      else $error("occupancy count disagrees with valid entries");

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key present in more than one entry");

   a_victim: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |-> victim.valid && valid_vec[victim.index])
      else $error("eviction without a valid victim");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> free_found)
      else $error("insert without a free entry");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFU key-value store with LRU tie-break.
// Drives get and put words through a queue fed driver and predicts every
// response with its own model of the store, capacity, use counts and ages.
// The capacity register is rewritten between phases, only once the store has
// gone idle. Both channels idle in random bursts until the last phase.
// ----------------------------------------------------------------------------
module tb;
   import lfuc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 300;
   localparam int POOL_KEYS      = 24;

   logic                clock;
   logic                reset;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CAP_BITS-1:0] csr_data;

   lfu_cache_lru_tiebreak_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predicted store contents
   logic                  slot_valid [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
   logic [DATA_BITS-1:0]  slot_data  [ENTRIES];
   logic [COUNT_BITS-1:0] slot_count [ENTRIES];
   int                    slot_age   [ENTRIES];
   int                    capacity_now;

   req_word_type pending_words [$];
   rsp_word_type due_responses [$];
   rsp_word_type due_word;

   int  words_queued;
   int  words_taken;
   int  responses_seen;
   int  hits_predicted;
   int  evictions_predicted;
   int  settings_written;
   int  errors;
   int  req_gap;
   int  stall_gap;
   int  quiet_cycles;
   bit  quiet;
   logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void make_youngest(int e);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && i != e && slot_age[i] < slot_age[e])
            slot_age[i]++;
      slot_age[e] = 0;
   endfunction

   function automatic void count_hit(int e);
      if (slot_count[e] != '1)
         slot_count[e]++;
      make_youngest(e);
   endfunction

   function automatic int occupied_slots();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i])
            n++;
      return n;
   endfunction

   // lowest count goes first, the oldest among equal counts
   function automatic void evict_victim();
      int v;
      v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
               (slot_count[i] == slot_count[v] && slot_age[i] > slot_age[v])))
            v = i;
      end
      if (v >= 0) begin
         slot_valid[v] = 1'b0;
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > slot_age[v])
               slot_age[i]--;
         evictions_predicted++;
      end
   endfunction

   function automatic rsp_word_type cache_lookup(req_word_type w);
      int           found;
      int           room;
      int           slot;
      rsp_word_type r;
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_key[i] == w.lookup_key)
            found = i;
      room = (capacity_now > ENTRIES) ? ENTRIES : capacity_now;
      r.hit = (found >= 0);
      r.read_value = '1;
      if (found >= 0)
         hits_predicted++;
      if (w.func == FUNC_GET) begin
         if (found >= 0) begin
            r.read_value = slot_data[found];
            count_hit(found);
         end
      end else if (room > 0) begin
         if (found >= 0) begin
            slot_data[found] = w.write_value;
            count_hit(found);
         end else begin
            while (occupied_slots() >= room)
               evict_victim();
            slot = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!slot_valid[i])
                  slot = i;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_valid[i])
                  slot_age[i]++;
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = w.lookup_key;
            slot_data[slot]  = w.write_value;
            slot_count[slot] = 1;
            slot_age[slot]   = 0;
         end
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            due_responses.push_back(cache_lookup(req_data));
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
               req_gap   <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (due_responses.size() == 0) begin
               $display("%0t: response with none due: hit %0b value %h",
                        $time, rsp_data.hit, rsp_data.read_value);
               errors++;
            end else begin
               due_word = due_responses.pop_front();
               if (rsp_data.hit !== due_word.hit) begin
                  $display("%0t: hit mismatch: expected %0b actual %0b",
                           $time, due_word.hit, rsp_data.hit);
                  errors++;
               end
               if (rsp_data.read_value !== due_word.read_value) begin
                  $display("%0t: read_value mismatch: expected %h actual %h",
                           $time, due_word.read_value, rsp_data.read_value);
                  errors++;
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_gap <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(input logic f, input logic [31:0] k, input logic [31:0] v);
      req_word_type w;
      w.func        = f;
      w.lookup_key  = k;
      w.write_value = v;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // sender holds off until every response has come back
   task automatic drain();
      do
         @(posedge clock);
      while (words_taken != words_queued || due_responses.size() != 0);
   endtask

   // called once drain has returned, with the store idle
   task automatic write_capacity(input logic [CAP_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      capacity_now = int'(v);
      settings_written++;
   endtask

   task automatic random_phase(input int n);
      int room;
      int span;
      int hot;
      int pick;
      logic [KEY_BITS-1:0] k;
      room = (capacity_now > ENTRIES) ? ENTRIES : capacity_now;
      span = (room + 4 > POOL_KEYS) ? POOL_KEYS : room + 4;
      hot  = (span / 3 < 1) ? 1 : span / 3;
      for (int i = 0; i < POOL_KEYS; i++)
         if ($urandom_range(0, 1) == 1)
            key_pool[i] = $urandom;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            k = $urandom;
         else if (pick < 55)
            k = key_pool[$urandom_range(0, hot - 1)];
         else
            k = key_pool[$urandom_range(0, span - 1)];
         push_word(($urandom_range(0, 99) < 45) ? FUNC_GET : FUNC_PUT, k, $urandom);
      end
   endtask

   initial begin
      int phase_caps [10];
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_data  = '0;
      quiet     = 1'b0;
      capacity_now = int'(CAP_RESET);
      for (int i = 0; i < ENTRIES; i++)
         slot_valid[i] = 1'b0;
      for (int i = 0; i < POOL_KEYS; i++)
         key_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty store, extreme keys and values, put hit overwrite
      push_word(FUNC_GET, 32'h0000_0000, 32'h1111_1111);
      push_word(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      push_word(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      push_word(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      push_word(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      push_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
      push_word(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_word(FUNC_GET, 32'h8000_0000, 32'h0);
      push_word(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
      push_word(FUNC_GET, 32'h0000_0000, 32'h0);
      push_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
      drain();

      // capacity dropped below occupancy, a put miss evicts several
      write_capacity(CAP_BITS'(2));
      push_word(FUNC_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
      push_word(FUNC_GET, 32'h5555_5555, 32'h0);
      push_word(FUNC_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
      drain();

      // zero capacity: puts change nothing, gets still see the store
      write_capacity(CAP_BITS'(0));
      push_word(FUNC_PUT, 32'h5555_5555, 32'h0000_0001);
      push_word(FUNC_PUT, 32'h1357_9BDF, 32'h0000_0002);
      push_word(FUNC_GET, 32'h5555_5555, 32'h0);
      push_word(FUNC_GET, 32'h1357_9BDF, 32'h0);
      drain();

      // equal counts: the oldest goes
      write_capacity(CAP_BITS'(3));
      push_word(FUNC_PUT, 32'h0000_0001, 32'h0000_0010);
      push_word(FUNC_PUT, 32'h0000_0002, 32'h0000_0020);
      push_word(FUNC_PUT, 32'h0000_0003, 32'h0000_0030);
      push_word(FUNC_PUT, 32'h0000_0004, 32'h0000_0040);
      push_word(FUNC_GET, 32'h0000_0002, 32'h0);
      push_word(FUNC_GET, 32'h0000_0004, 32'h0);
      drain();

      phase_caps = '{31, 1, 16, 3, 0, 17, 2, 8, 0, 16};
      phase_caps[8] = int'($urandom_range(0, 31));
      for (int p = 0; p < 10; p++) begin
         write_capacity(CAP_BITS'(phase_caps[p]));
         if (p == 9)
            quiet = 1'b1;
         random_phase(113);
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d words, %0d responses, %0d hits, %0d evictions",
               words_queued, responses_seen, hits_predicted, evictions_predicted);
      $display("over %0d capacity settings, %0d mismatches", settings_written, errors);
      if (errors == 0 && due_responses.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
